[sv/pulse_width_command_sender_defines.svh]
// Assertion macros shared by the pulse width command sender RTL.
`ifndef PULSE_WIDTH_COMMAND_SENDER_DEFINES_SVH
`define PULSE_WIDTH_COMMAND_SENDER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PWCS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PWCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pwcs_pkg.sv]
// Package with the types and constants of the pulse width command sender.
`default_nettype none
package pwcs_pkg;

    // Width of one timing register and of the configuration address.
    localparam int CFG_BITS  = 20;
    localparam int ADDR_BITS = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_LOW = 2'd0;
    localparam logic [1:0] REG_SHORT     = 2'd1;
    localparam logic [1:0] REG_LONG      = 2'd2;
    localparam logic [1:0] REG_STOP_HIGH = 2'd3;

    // Reset values of the timing registers.
    localparam logic [CFG_BITS-1:0] RST_START_LOW = 20'd5000;
    localparam logic [CFG_BITS-1:0] RST_SHORT     = 20'd700;
    localparam logic [CFG_BITS-1:0] RST_LONG      = 20'd2100;
    localparam logic [CFG_BITS-1:0] RST_STOP_HIGH = 20'd50000;

    // Frame phase codes.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START    = 3'd1;
    localparam logic [2:0] PH_BIT_HIGH = 3'd2;
    localparam logic [2:0] PH_BIT_LOW  = 3'd3;
    localparam logic [2:0] PH_STOP     = 3'd4;

    // Timing settings handed from the register block to the sender.
    typedef struct packed {
        logic [CFG_BITS-1:0] start_low_ticks;
        logic [CFG_BITS-1:0] short_ticks;
        logic [CFG_BITS-1:0] long_ticks;
        logic [CFG_BITS-1:0] stop_high_ticks;
    } cfg_t;

endpackage
`default_nettype wire

[sv/pwcs_cfg_regs.sv]
// APB register block that holds the four timing settings.
`default_nettype none
module pwcs_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pwcs_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output pwcs_pkg::cfg_t                     cfg
);

    pwcs_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks <= pwcs_pkg::RST_START_LOW;
            cfg_reg.short_ticks     <= pwcs_pkg::RST_SHORT;
            cfg_reg.long_ticks      <= pwcs_pkg::RST_LONG;
            cfg_reg.stop_high_ticks <= pwcs_pkg::RST_STOP_HIGH;
        end else if (wr_en) begin
            case (paddr[3:2])
                pwcs_pkg::REG_START_LOW: begin
                    cfg_reg.start_low_ticks <= pwdata[pwcs_pkg::CFG_BITS-1:0];
                end
                pwcs_pkg::REG_SHORT: begin
                    cfg_reg.short_ticks <= pwdata[pwcs_pkg::CFG_BITS-1:0];
                end
                pwcs_pkg::REG_LONG: begin
                    cfg_reg.long_ticks <= pwdata[pwcs_pkg::CFG_BITS-1:0];
                end
                pwcs_pkg::REG_STOP_HIGH: begin
                    cfg_reg.stop_high_ticks <= pwdata[pwcs_pkg::CFG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (paddr[3:2])
            pwcs_pkg::REG_START_LOW: prdata = 32'(cfg_reg.start_low_ticks);
            pwcs_pkg::REG_SHORT:     prdata = 32'(cfg_reg.short_ticks);
            pwcs_pkg::REG_LONG:      prdata = 32'(cfg_reg.long_ticks);
            pwcs_pkg::REG_STOP_HIGH: prdata = 32'(cfg_reg.stop_high_ticks);
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[sv/pulse_width_command_sender.sv]
// A result word is registered in the output register when its tick word is accepted.
// Throughput: one tick word per cycle; the output register lets a new word in
// whenever it is empty or its word is taken in the same cycle.
// Each phase lasts its register's tick count (zero counts as one), counted by one TIMER_BITS down counter.
// Reset (aresetn low, synchronous) idles the line high, clears the frame state
// and the output valid, and loads the timing registers with their defaults.
`default_nettype none
`include "pulse_width_command_sender_defines.svh"
module pulse_width_command_sender #(
    parameter int TIMER_BITS = 20
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input tick words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [7:0] command_byte
    input  wire logic                           s_tuser,  // [0] send_request
    // Result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [7:0]                     m_tdata,  // [0] line_level, [1] busy_res,
                                                           // [2] request_ignored, rest zero
    output logic                                m_tlast,  // frame_done
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pwcs_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam logic [TIMER_BITS-1:0] TICK_ONE = TIMER_BITS'(1);

    pwcs_pkg::cfg_t cfg;

    // Frame state
    logic [2:0]            phase_reg, phase_next;
    logic [2:0]            pos_reg, pos_next;
    logic [7:0]            shift_reg, shift_next;
    logic [TIMER_BITS-1:0] ticks_reg, ticks_next;

    // Working copy of the state after a possible frame start
    logic [2:0]            cur_phase;
    logic [2:0]            cur_pos;
    logic [7:0]            cur_shift;
    logic [TIMER_BITS-1:0] cur_ticks;

    // Result of this tick
    logic level, busy, done, ignored;

    // Output register
    logic       out_valid_reg;
    logic [2:0] out_data_reg;
    logic       out_last_reg;

    logic in_acc;

    pwcs_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Phase length as loaded into the counter; zero counts as one tick.
    function automatic logic [TIMER_BITS-1:0] timer_load(
        input logic [pwcs_pkg::CFG_BITS-1:0] v
    );
        logic [TIMER_BITS-1:0] r;
        r = TIMER_BITS'(v);
        return (r == '0) ? TICK_ONE : r;
    endfunction

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    // Frame start and phase sequencing for one tick.
    always_comb begin
        ignored = s_tuser && (phase_reg != pwcs_pkg::PH_IDLE);
        if (phase_reg == pwcs_pkg::PH_IDLE && s_tuser) begin
            cur_phase = pwcs_pkg::PH_START;
            cur_ticks = timer_load(cfg.start_low_ticks);
            cur_shift = s_tdata;
            cur_pos   = '0;
        end else begin
            cur_phase = phase_reg;
            cur_ticks = ticks_reg;
            cur_shift = shift_reg;
            cur_pos   = pos_reg;
        end

        phase_next = cur_phase;
        ticks_next = cur_ticks;
        shift_next = cur_shift;
        pos_next   = cur_pos;
        level      = 1'b1;
        busy       = 1'b0;
        done       = 1'b0;

        if (cur_phase != pwcs_pkg::PH_IDLE) begin
            busy  = 1'b1;
            level = !(cur_phase == pwcs_pkg::PH_START || cur_phase == pwcs_pkg::PH_BIT_LOW);
            if (cur_ticks > TICK_ONE) begin
                ticks_next = cur_ticks - TICK_ONE;
            end else begin
                case (cur_phase)
                    pwcs_pkg::PH_START: begin
                        phase_next = pwcs_pkg::PH_BIT_HIGH;
                        ticks_next = timer_load(cur_shift[0] ? cfg.long_ticks
                                                             : cfg.short_ticks);
                    end
                    pwcs_pkg::PH_BIT_HIGH: begin
                        phase_next = pwcs_pkg::PH_BIT_LOW;
                        ticks_next = timer_load(cur_shift[0] ? cfg.short_ticks
                                                             : cfg.long_ticks);
                    end
                    pwcs_pkg::PH_BIT_LOW: begin
                        if (cur_pos == 3'd7) begin
                            phase_next = pwcs_pkg::PH_STOP;
                            ticks_next = timer_load(cfg.stop_high_ticks);
                        end else begin
                            // Next bit comes from the byte shifted by one.
                            pos_next   = cur_pos + 3'd1;
                            shift_next = {1'b0, cur_shift[7:1]};
                            phase_next = pwcs_pkg::PH_BIT_HIGH;
                            ticks_next = timer_load(cur_shift[1] ? cfg.long_ticks
                                                                 : cfg.short_ticks);
                        end
                    end
                    pwcs_pkg::PH_STOP: begin
                        done       = 1'b1;
                        phase_next = pwcs_pkg::PH_IDLE;
                        ticks_next = '0;
                    end
                    default: begin
                        phase_next = pwcs_pkg::PH_IDLE;
                        ticks_next = '0;
                    end
                endcase
            end
        end
    end

    // State advances once per accepted tick word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pwcs_pkg::PH_IDLE;
            pos_reg   <= '0;
            shift_reg <= '0;
            ticks_reg <= '0;
        end else if (in_acc) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            ticks_reg <= ticks_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_data_reg <= {ignored, busy, level};
            out_last_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

    // The counter is empty exactly when no frame is running.
    `PWCS_ASSERT_SAME(a_idle_timer_zero, aclk, aresetn,
        phase_reg == pwcs_pkg::PH_IDLE, ticks_reg == '0,
        "timer not empty while idle")
    `PWCS_ASSERT_SAME(a_busy_timer_set, aclk, aresetn,
        phase_reg != pwcs_pkg::PH_IDLE, ticks_reg != '0,
        "timer empty during a frame")
    // A finished frame always reports busy on its last tick and returns to idle.
    `PWCS_ASSERT_SAME(a_done_busy, aclk, aresetn,
        m_tvalid && m_tlast, m_tdata[1] && phase_reg == pwcs_pkg::PH_IDLE,
        "frame done without busy or idle return")
    // An accepted word always leaves a result word behind.
    `PWCS_ASSERT_NEXT(a_acc_result, aclk, aresetn,
        in_acc, m_tvalid,
        "accepted tick word produced no result word")

endmodule
`default_nettype wire

[dv/tb_pulse_width_command_sender.sv]
// Self-checking testbench for the pulse width command sender: tick words in, line words out.
`timescale 1ns / 100ps
module tb_pulse_width_command_sender;

    localparam int TIMER_BITS  = 20;
    localparam int HOLD_CYCLES = 300;

    // One line word as the sender drives it for one tick.
    typedef struct packed {
        logic level;
        logic busy;
        logic done;
        logic ignored;
    } line_word_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic       req;
        logic [7:0] cmd;
        logic [7:0] reps;
        logic       typed;
        line_word_t want;
    } tick_row_t;

    localparam line_word_t IDLE_WORD         = '{1'b1, 1'b0, 1'b0, 1'b0};
    localparam line_word_t START_WORD        = '{1'b0, 1'b1, 1'b0, 1'b0};
    localparam line_word_t DONE_IGNORED_WORD = '{1'b1, 1'b1, 1'b1, 1'b1};
    localparam line_word_t NO_WORD           = '{1'b0, 1'b0, 1'b0, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] command_byte
    logic        s_tuser;   // [0] send_request
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] line_level, [1] busy_res, [2] request_ignored
    logic        m_tlast;   // frame_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [pwcs_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Expectation attached to the word currently offered, when the table types one in.
    logic        row_typed;
    line_word_t  row_want;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_request;
    int          mismatch_count;

    // Shadow of the sender state and its timing registers.
    pwcs_pkg::cfg_t        timing;
    logic [2:0]            tx_phase;
    logic [3:0]            tx_bit;
    logic [7:0]            tx_byte;
    logic [TIMER_BITS-1:0] ticks_left;

    line_word_t line_words_due[$];
    tick_row_t  dir_rows[0:5];

    pulse_width_command_sender #(.TIMER_BITS(TIMER_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // A phase length of zero still lasts one tick.
    function automatic logic [TIMER_BITS-1:0] phase_length(
        input logic [pwcs_pkg::CFG_BITS-1:0] v
    );
        logic [TIMER_BITS-1:0] r;
        r = TIMER_BITS'(v);
        return (r == '0) ? TIMER_BITS'(1) : r;
    endfunction

    // Advances the shadow sender by one tick and returns the line word it drives.
    function automatic line_word_t step_sender(input logic req, input logic [7:0] cmd);
        line_word_t r;
        logic       b;
        r = IDLE_WORD;
        if (tx_phase == pwcs_pkg::PH_IDLE) begin
            if (req) begin
                tx_byte    = cmd;
                tx_bit     = '0;
                tx_phase   = pwcs_pkg::PH_START;
                ticks_left = phase_length(timing.start_low_ticks);
            end
        end else if (req) begin
            r.ignored = 1'b1;
        end
        if (tx_phase != pwcs_pkg::PH_IDLE) begin
            r.busy  = 1'b1;
            r.level = !(tx_phase == pwcs_pkg::PH_START || tx_phase == pwcs_pkg::PH_BIT_LOW);
            if (ticks_left > 1) begin
                ticks_left--;
            end else begin
                b = tx_byte[0];
                case (tx_phase)
                    pwcs_pkg::PH_START: begin
                        tx_phase   = pwcs_pkg::PH_BIT_HIGH;
                        ticks_left = phase_length(b ? timing.long_ticks : timing.short_ticks);
                    end
                    pwcs_pkg::PH_BIT_HIGH: begin
                        tx_phase   = pwcs_pkg::PH_BIT_LOW;
                        ticks_left = phase_length(b ? timing.short_ticks : timing.long_ticks);
                    end
                    pwcs_pkg::PH_BIT_LOW: begin
                        if (tx_bit >= 4'd7) begin
                            tx_phase   = pwcs_pkg::PH_STOP;
                            ticks_left = phase_length(timing.stop_high_ticks);
                        end else begin
                            tx_bit     = tx_bit + 4'd1;
                            tx_byte    = tx_byte >> 1;
                            tx_phase   = pwcs_pkg::PH_BIT_HIGH;
                            b          = tx_byte[0];
                            ticks_left = phase_length(b ? timing.long_ticks : timing.short_ticks);
                        end
                    end
                    default: begin
                        r.done     = 1'b1;
                        tx_phase   = pwcs_pkg::PH_IDLE;
                        ticks_left = '0;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Predicts on each accepted tick word and checks each accepted line word.
    always @(posedge aclk) begin : check_words
        line_word_t                    got;
        line_word_t                    want;
        line_word_t                    pred;
        logic [pwcs_pkg::CFG_BITS-1:0] wval;
        if (!aresetn) begin
            timing     = '{pwcs_pkg::RST_START_LOW, pwcs_pkg::RST_SHORT,
                           pwcs_pkg::RST_LONG, pwcs_pkg::RST_STOP_HIGH};
            tx_phase   = pwcs_pkg::PH_IDLE;
            tx_bit     = '0;
            tx_byte    = '0;
            ticks_left = '0;
            line_words_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[1], m_tlast, m_tdata[2]};
                if (line_words_due.size() == 0) begin
                    report_mismatch($sformatf("line word %b with nothing pending", got));
                end else begin
                    want = line_words_due.pop_front();
                    if (got.level !== want.level)
                        report_mismatch($sformatf("line_level %b, want %b", got.level, want.level));
                    if (got.busy !== want.busy)
                        report_mismatch($sformatf("busy_res %b, want %b", got.busy, want.busy));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("frame_done %b, want %b", got.done, want.done));
                    if (got.ignored !== want.ignored)
                        report_mismatch($sformatf("request_ignored %b, want %b",
                                                  got.ignored, want.ignored));
                end
            end
            if (psel && penable && pwrite && pready) begin
                wval = pwdata[pwcs_pkg::CFG_BITS-1:0];
                case (paddr[3:2])
                    pwcs_pkg::REG_START_LOW: timing.start_low_ticks = wval;
                    pwcs_pkg::REG_SHORT:     timing.short_ticks     = wval;
                    pwcs_pkg::REG_LONG:      timing.long_ticks      = wval;
                    default:                 timing.stop_high_ticks = wval;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pred = step_sender(s_tuser, s_tdata);
                line_words_due.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_tready = 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Writes one timing register and reads it back. Called at a falling edge.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== {12'b0, val[pwcs_pkg::CFG_BITS-1:0]})
            report_mismatch($sformatf("register %0d reads %h after writing %h", idx, rd, val));
    endtask

    task automatic program_timing(input logic [31:0] start_v, input logic [31:0] short_v,
                                  input logic [31:0] long_v, input logic [31:0] stop_v);
        write_register(pwcs_pkg::REG_START_LOW, start_v);
        write_register(pwcs_pkg::REG_SHORT, short_v);
        write_register(pwcs_pkg::REG_LONG, long_v);
        write_register(pwcs_pkg::REG_STOP_HIGH, stop_v);
    endtask

    // Offers one tick word, with random gaps ahead of it. Starts and ends at a falling edge.
    task automatic send_tick(input logic req, input logic [7:0] cmd,
                             input logic typed, input line_word_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = req;
        s_tdata   = cmd;
        row_typed = typed;
        row_want  = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every line word has come back.
    task automatic drain_line_words();
        s_tvalid  = 1'b0;
        row_typed = 1'b0;
        while (line_words_due.size() != 0) @(negedge aclk);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        row_typed      = 1'b0;
        row_want       = NO_WORD;
        hold_request   = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 34;
        recv_idle_pct  = 84;

        // An 0x80 frame with every phase one tick long: a request while busy,
        // a request on the frame_done tick, and a new frame on the next tick.
        dir_rows[0] = '{1'b0, 8'hFF, 8'd1,  1'b1, IDLE_WORD};
        dir_rows[1] = '{1'b1, 8'h80, 8'd1,  1'b1, START_WORD};
        dir_rows[2] = '{1'b1, 8'h5A, 8'd1,  1'b0, NO_WORD};
        dir_rows[3] = '{1'b0, 8'h00, 8'd15, 1'b0, NO_WORD};
        dir_rows[4] = '{1'b1, 8'h01, 8'd1,  1'b1, DONE_IGNORED_WORD};
        dir_rows[5] = '{1'b1, 8'hFF, 8'd1,  1'b1, START_WORD};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Zero lengths all act as one tick.
        program_timing(32'd0, 32'd0, 32'd0, 32'd0);
        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps) begin
                send_tick(dir_rows[i].req, dir_rows[i].cmd, 1'b1 & dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end
        drain_line_words();

        // Random ticks under three idling mixes and four timing settings each.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 84 : 0;
            recv_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 34 : 0;
            for (int s = 0; s < 4; s++) begin
                drain_line_words();
                case (s)
                    0: program_timing(32'd1, 32'd1, 32'd1, 32'd1);
                    1: program_timing(32'd3, 32'd1, 32'd4, 32'd2);
                    2: program_timing({12'($urandom), 20'($urandom_range(6, 1))},
                                      {12'($urandom), 20'($urandom_range(6, 1))},
                                      {12'($urandom), 20'($urandom_range(6, 1))},
                                      {12'($urandom), 20'($urandom_range(6, 1))});
                    default: program_timing(32'($urandom_range(3)), 32'($urandom_range(3)),
                                            32'($urandom_range(3)), 32'($urandom_range(3)));
                endcase
                // With no idling, the receiver holds off while ticks keep coming.
                if (mode == 2 && s == 0) hold_request = 1'b1;
                repeat (90) begin
                    send_tick($urandom_range(99) < 20, 8'($urandom), 1'b0, NO_WORD);
                end
            end
        end

        // Longest phases: the frame stays in its start period to the end.
        drain_line_words();
        program_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(1'b1, 8'($urandom), 1'b0, NO_WORD);
        repeat (39) send_tick($urandom_range(1), 8'($urandom), 1'b0, NO_WORD);
        drain_line_words();

        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_pulse_width_command_sender: PASS");
        end else begin
            $display("tb_pulse_width_command_sender: FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #6000000;
        $display("tb_pulse_width_command_sender: FAIL");
        $finish;
    end

endmodule
